>>> rtl/core/sst_pkg.sv
package sst_pkg;

  localparam int POS_BITS   = 24;
  localparam int KW_MAX_LEN = 8;
  localparam int KW_COUNT   = 15;
  localparam int KW_BITS    = 8 * KW_MAX_LEN;
  localparam int WLEN_BITS  = $clog2(KW_MAX_LEN + 2);
  localparam int WIDX_BITS  = $clog2(KW_MAX_LEN);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [23:0]         CNT_MAX = 24'hFFFFFF;

  // token kinds
  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd1;
  localparam logic [5:0] K_INT      = 6'd2;
  localparam logic [5:0] K_FLOAT    = 6'd3;
  localparam logic [5:0] K_STRING   = 6'd4;
  localparam logic [5:0] K_KW_FIRST = 6'd5;
  localparam logic [5:0] K_PLUS     = 6'd20;
  localparam logic [5:0] K_ARROW    = 6'd21;
  localparam logic [5:0] K_MINUS    = 6'd22;
  localparam logic [5:0] K_POW      = 6'd23;
  localparam logic [5:0] K_STAR     = 6'd24;
  localparam logic [5:0] K_SLASH    = 6'd25;
  localparam logic [5:0] K_PERCENT  = 6'd26;
  localparam logic [5:0] K_EQEQ     = 6'd27;
  localparam logic [5:0] K_ASSIGN   = 6'd28;
  localparam logic [5:0] K_NE       = 6'd29;
  localparam logic [5:0] K_BANG     = 6'd30;
  localparam logic [5:0] K_LE       = 6'd31;
  localparam logic [5:0] K_LT       = 6'd32;
  localparam logic [5:0] K_GE       = 6'd33;
  localparam logic [5:0] K_GT       = 6'd34;
  localparam logic [5:0] K_ANDAND   = 6'd35;
  localparam logic [5:0] K_OROR     = 6'd36;
  localparam logic [5:0] K_COLON    = 6'd37;
  localparam logic [5:0] K_SEMI     = 6'd38;
  localparam logic [5:0] K_COMMA    = 6'd39;
  localparam logic [5:0] K_DOT      = 6'd40;
  localparam logic [5:0] K_LPAREN   = 6'd41;
  localparam logic [5:0] K_RPAREN   = 6'd42;
  localparam logic [5:0] K_LBRACE   = 6'd43;
  localparam logic [5:0] K_RBRACE   = 6'd44;
  localparam logic [5:0] K_LBRACK   = 6'd45;
  localparam logic [5:0] K_RBRACK   = 6'd46;
  localparam logic [5:0] K_ERROR    = 6'd47;

  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_UNTERM   = 3'd1,
    E_LONE_AMP = 3'd2,
    E_LONE_BAR = 3'd3,
    E_BAD_BYTE = 3'd4
  } err_e;

  typedef enum logic [18:0] {
    M_IDLE       = 19'h00001,
    M_IDENT      = 19'h00002,
    M_NUM        = 19'h00004,
    M_NUM_DOT    = 19'h00008,
    M_FRAC       = 19'h00010,
    M_STR        = 19'h00020,
    M_STR_ESC    = 19'h00040,
    M_SLASH      = 19'h00080,
    M_LINE_CMT   = 19'h00100,
    M_BLOCK_CMT  = 19'h00200,
    M_BLOCK_STAR = 19'h00400,
    M_OP_MINUS   = 19'h00800,
    M_OP_STAR    = 19'h01000,
    M_OP_EQ      = 19'h02000,
    M_OP_BANG    = 19'h04000,
    M_OP_LT      = 19'h08000,
    M_OP_GT      = 19'h10000,
    M_OP_AMP     = 19'h20000,
    M_OP_BAR     = 19'h40000
  } mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    err_e        err;
    logic [23:0] start;
    logic [23:0] len;
    logic [23:0] line;
  } tok_t;

  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     res;
  } bundle_t;

  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    KW_BITS'("fn"), KW_BITS'("if"), KW_BITS'("else"), KW_BITS'("while"), KW_BITS'("for"),
    KW_BITS'("return"), KW_BITS'("class"), KW_BITS'("use"), KW_BITS'("const"),
    KW_BITS'("break"), KW_BITS'("continue"), KW_BITS'("match"), KW_BITS'("try"),
    KW_BITS'("catch"), KW_BITS'("yield")
  };
  localparam logic [WLEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
    WLEN_BITS'(2), WLEN_BITS'(2), WLEN_BITS'(4), WLEN_BITS'(5), WLEN_BITS'(3),
    WLEN_BITS'(6), WLEN_BITS'(5), WLEN_BITS'(3), WLEN_BITS'(5), WLEN_BITS'(5),
    WLEN_BITS'(8), WLEN_BITS'(5), WLEN_BITS'(3), WLEN_BITS'(5), WLEN_BITS'(5)
  };

  // word bytes are packed right aligned so they compare to plain string literals
  function automatic logic [5:0] kw_kind(input logic [KW_MAX_LEN-1:0][7:0] w,
                                         input logic [WLEN_BITS-1:0] n);
    logic [KW_BITS-1:0] r;
    logic [5:0]         k;
    r = '0;
    k = K_IDENT;
    for (int j = 0; j < KW_MAX_LEN; j++) begin
      if (j < int'(n)) r = {r[KW_BITS-9:0], w[j]};
    end
    for (int i = 0; i < KW_COUNT; i++) begin
      if (KW_LEN[i] == n && KW_TEXT[i] == r) k = K_KW_FIRST + 6'(i);
    end
    return k;
  endfunction

endpackage

>>> rtl/core/sst_scan.sv
module sst_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         ch_i,
  input  logic               is_end_i,
  output sst_pkg::bundle_t   bundle_o
);

  sst_pkg::mode_e                             mode_q, mode_d;
  logic                                       quote_q, quote_d;
  logic [sst_pkg::WLEN_BITS-1:0]              wlen_q, wlen_d;
  logic [sst_pkg::POS_BITS-1:0]               begin_q, begin_d;
  logic [sst_pkg::POS_BITS-1:0]               pos_q, pos_d;
  logic [23:0]                                line_q, line_d;
  logic [sst_pkg::KW_MAX_LEN-1:0][7:0]        wc_q;
  logic                                       wc_we;
  logic [sst_pkg::WIDX_BITS-1:0]              wc_idx;

  function automatic logic [23:0] span(input logic [sst_pkg::POS_BITS-1:0] e,
                                       input logic [sst_pkg::POS_BITS-1:0] b);
    return (e >= b) ? 24'(e - b) : 24'd0;
  endfunction

  function automatic sst_pkg::tok_t mk(input logic [5:0] k, input sst_pkg::err_e e,
                                       input logic [sst_pkg::POS_BITS-1:0] s,
                                       input logic [23:0] l, input logic [23:0] ln);
    sst_pkg::tok_t t;
    t.kind  = k;
    t.err   = e;
    t.start = 24'(s);
    t.len   = l;
    t.line  = ln;
    return t;
  endfunction

  logic                          absorbed;
  logic                          is_alpha, is_digit;
  logic [sst_pkg::POS_BITS-1:0]  nxt, dp;
  logic [23:0]                   line_inc;
  logic [7:0]                    op_sec;
  logic [5:0]                    op_two, op_one, k1;
  sst_pkg::err_e                 op_err;
  logic [1:0]                    cnt;
  sst_pkg::tok_t [2:0]           res;

  assign is_alpha = (ch_i >= "a" && ch_i <= "z") || (ch_i >= "A" && ch_i <= "Z") ||
                    ch_i == "_";
  assign is_digit = ch_i >= "0" && ch_i <= "9";
  assign nxt      = (pos_q != sst_pkg::POS_MAX) ? pos_q + 1'b1 : pos_q;
  assign dp       = (pos_q > begin_q) ? pos_q - 1'b1 : pos_q;
  assign line_inc = (line_q != sst_pkg::CNT_MAX) ? line_q + 24'd1 : line_q;

  always_comb begin
    op_sec = ">";
    op_two = sst_pkg::K_ARROW;
    op_one = sst_pkg::K_MINUS;
    op_err = sst_pkg::E_NONE;
    unique case (mode_q)
      sst_pkg::M_OP_STAR: begin
        op_sec = "*"; op_two = sst_pkg::K_POW;    op_one = sst_pkg::K_STAR;
      end
      sst_pkg::M_OP_EQ: begin
        op_sec = "="; op_two = sst_pkg::K_EQEQ;   op_one = sst_pkg::K_ASSIGN;
      end
      sst_pkg::M_OP_BANG: begin
        op_sec = "="; op_two = sst_pkg::K_NE;     op_one = sst_pkg::K_BANG;
      end
      sst_pkg::M_OP_LT: begin
        op_sec = "="; op_two = sst_pkg::K_LE;     op_one = sst_pkg::K_LT;
      end
      sst_pkg::M_OP_GT: begin
        op_sec = "="; op_two = sst_pkg::K_GE;     op_one = sst_pkg::K_GT;
      end
      sst_pkg::M_OP_AMP: begin
        op_sec = "&"; op_two = sst_pkg::K_ANDAND; op_one = sst_pkg::K_ERROR;
        op_err = sst_pkg::E_LONE_AMP;
      end
      sst_pkg::M_OP_BAR: begin
        op_sec = "|"; op_two = sst_pkg::K_OROR;   op_one = sst_pkg::K_ERROR;
        op_err = sst_pkg::E_LONE_BAR;
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    quote_d  = quote_q;
    wlen_d   = wlen_q;
    begin_d  = begin_q;
    pos_d    = pos_q;
    line_d   = line_q;
    wc_we    = 1'b0;
    wc_idx   = wlen_q[sst_pkg::WIDX_BITS-1:0];
    absorbed = 1'b0;
    cnt      = 2'd0;
    res      = '0;
    k1       = 6'd0;

    if (!is_end_i) begin
      unique case (mode_q)
        sst_pkg::M_IDLE: ;
        sst_pkg::M_IDENT: begin
          if (is_alpha || is_digit) begin
            absorbed = 1'b1;
            if (wlen_q < sst_pkg::WLEN_BITS'(sst_pkg::KW_MAX_LEN)) wc_we = 1'b1;
            if (wlen_q <= sst_pkg::WLEN_BITS'(sst_pkg::KW_MAX_LEN)) wlen_d = wlen_q + 1'b1;
          end
        end
        sst_pkg::M_NUM: begin
          if (is_digit) absorbed = 1'b1;
          else if (ch_i == ".") begin
            absorbed = 1'b1;
            mode_d   = sst_pkg::M_NUM_DOT;
          end
        end
        sst_pkg::M_NUM_DOT: begin
          if (is_digit) begin
            absorbed = 1'b1;
            mode_d   = sst_pkg::M_FRAC;
          end
        end
        sst_pkg::M_FRAC: absorbed = is_digit;
        sst_pkg::M_STR: begin
          absorbed = 1'b1;
          if (ch_i == (quote_q ? 8'h27 : 8'h22)) begin
            res[cnt] = mk(sst_pkg::K_STRING, sst_pkg::E_NONE, begin_q,
                          span(nxt, begin_q), line_q);
            cnt      = cnt + 2'd1;
            mode_d   = sst_pkg::M_IDLE;
          end else if (ch_i == 8'h5C) begin
            mode_d = sst_pkg::M_STR_ESC;
          end else if (ch_i == 8'h0A) begin
            line_d = line_inc;
          end
        end
        sst_pkg::M_STR_ESC: begin
          absorbed = 1'b1;
          mode_d   = sst_pkg::M_STR;
        end
        sst_pkg::M_SLASH: begin
          if (ch_i == "/") begin
            absorbed = 1'b1;
            mode_d   = sst_pkg::M_LINE_CMT;
          end else if (ch_i == "*") begin
            absorbed = 1'b1;
            mode_d   = sst_pkg::M_BLOCK_CMT;
          end
        end
        sst_pkg::M_LINE_CMT: begin
          absorbed = 1'b1;
          if (ch_i == 8'h0A) begin
            line_d = line_inc;
            mode_d = sst_pkg::M_IDLE;
          end
        end
        sst_pkg::M_BLOCK_CMT: begin
          absorbed = 1'b1;
          if (ch_i == 8'h0A) line_d = line_inc;
          else if (ch_i == "*") mode_d = sst_pkg::M_BLOCK_STAR;
        end
        sst_pkg::M_BLOCK_STAR: begin
          absorbed = 1'b1;
          if (ch_i == "/") mode_d = sst_pkg::M_IDLE;
          else if (ch_i != "*") begin
            if (ch_i == 8'h0A) line_d = line_inc;
            mode_d = sst_pkg::M_BLOCK_CMT;
          end
        end
        sst_pkg::M_OP_MINUS, sst_pkg::M_OP_STAR, sst_pkg::M_OP_EQ, sst_pkg::M_OP_BANG,
        sst_pkg::M_OP_LT, sst_pkg::M_OP_GT, sst_pkg::M_OP_AMP, sst_pkg::M_OP_BAR: begin
          if (ch_i == op_sec) begin
            absorbed = 1'b1;
            res[cnt] = mk(op_two, sst_pkg::E_NONE, begin_q, span(nxt, begin_q), line_q);
            cnt      = cnt + 2'd1;
            mode_d   = sst_pkg::M_IDLE;
          end
        end
        default: ;
      endcase
    end

    // settle the pending token
    if (is_end_i || !absorbed) begin
      unique case (mode_q)
        sst_pkg::M_IDENT: begin
          res[cnt] = mk(sst_pkg::kw_kind(wc_q, wlen_q), sst_pkg::E_NONE, begin_q,
                        span(pos_q, begin_q), line_q);
          cnt      = cnt + 2'd1;
        end
        sst_pkg::M_NUM: begin
          res[cnt] = mk(sst_pkg::K_INT, sst_pkg::E_NONE, begin_q, span(pos_q, begin_q),
                        line_q);
          cnt      = cnt + 2'd1;
        end
        sst_pkg::M_FRAC: begin
          res[cnt] = mk(sst_pkg::K_FLOAT, sst_pkg::E_NONE, begin_q, span(pos_q, begin_q),
                        line_q);
          cnt      = cnt + 2'd1;
        end
        sst_pkg::M_NUM_DOT: begin
          res[cnt] = mk(sst_pkg::K_INT, sst_pkg::E_NONE, begin_q, span(dp, begin_q), line_q);
          cnt      = cnt + 2'd1;
          res[cnt] = mk(sst_pkg::K_DOT, sst_pkg::E_NONE, dp, 24'd1, line_q);
          cnt      = cnt + 2'd1;
        end
        sst_pkg::M_STR, sst_pkg::M_STR_ESC: begin
          res[cnt] = mk(sst_pkg::K_ERROR, sst_pkg::E_UNTERM, begin_q, span(pos_q, begin_q),
                        line_q);
          cnt      = cnt + 2'd1;
        end
        sst_pkg::M_SLASH: begin
          res[cnt] = mk(sst_pkg::K_SLASH, sst_pkg::E_NONE, begin_q, 24'd1, line_q);
          cnt      = cnt + 2'd1;
        end
        sst_pkg::M_OP_MINUS, sst_pkg::M_OP_STAR, sst_pkg::M_OP_EQ, sst_pkg::M_OP_BANG,
        sst_pkg::M_OP_LT, sst_pkg::M_OP_GT, sst_pkg::M_OP_AMP, sst_pkg::M_OP_BAR: begin
          res[cnt] = mk(op_one, op_err, begin_q, 24'd1, line_q);
          cnt      = cnt + 2'd1;
        end
        default: ;
      endcase
      mode_d = sst_pkg::M_IDLE;
    end

    if (is_end_i) begin
      res[cnt] = mk(sst_pkg::K_EOF, sst_pkg::E_NONE, pos_q, 24'd0, line_q);
      cnt      = cnt + 2'd1;
      mode_d   = sst_pkg::M_IDLE;
      quote_d  = 1'b0;
      wlen_d   = '0;
      begin_d  = '0;
      pos_d    = '0;
      line_d   = 24'd1;
    end else begin
      if (!absorbed) begin
        if (ch_i == 8'h20 || ch_i == 8'h0D || ch_i == 8'h09) begin
          // blank
        end else if (ch_i == 8'h0A) begin
          line_d = line_inc;
        end else if (is_alpha) begin
          mode_d  = sst_pkg::M_IDENT;
          begin_d = pos_q;
          wc_we   = 1'b1;
          wc_idx  = '0;
          wlen_d  = sst_pkg::WLEN_BITS'(1);
        end else if (is_digit) begin
          mode_d  = sst_pkg::M_NUM;
          begin_d = pos_q;
        end else if (ch_i == 8'h22 || ch_i == 8'h27) begin
          mode_d  = sst_pkg::M_STR;
          begin_d = pos_q;
          quote_d = (ch_i == 8'h27);
        end else begin
          unique case (ch_i)
            "/": mode_d = sst_pkg::M_SLASH;
            "-": mode_d = sst_pkg::M_OP_MINUS;
            "*": mode_d = sst_pkg::M_OP_STAR;
            "=": mode_d = sst_pkg::M_OP_EQ;
            "!": mode_d = sst_pkg::M_OP_BANG;
            "<": mode_d = sst_pkg::M_OP_LT;
            ">": mode_d = sst_pkg::M_OP_GT;
            "&": mode_d = sst_pkg::M_OP_AMP;
            "|": mode_d = sst_pkg::M_OP_BAR;
            "+": k1 = sst_pkg::K_PLUS;
            "%": k1 = sst_pkg::K_PERCENT;
            ":": k1 = sst_pkg::K_COLON;
            ";": k1 = sst_pkg::K_SEMI;
            ",": k1 = sst_pkg::K_COMMA;
            ".": k1 = sst_pkg::K_DOT;
            "(": k1 = sst_pkg::K_LPAREN;
            ")": k1 = sst_pkg::K_RPAREN;
            "{": k1 = sst_pkg::K_LBRACE;
            "}": k1 = sst_pkg::K_RBRACE;
            "[": k1 = sst_pkg::K_LBRACK;
            "]": k1 = sst_pkg::K_RBRACK;
            default: k1 = sst_pkg::K_ERROR;
          endcase
          if (mode_d != sst_pkg::M_IDLE) begin
            begin_d = pos_q;
          end else begin
            res[cnt] = mk(k1, (k1 == sst_pkg::K_ERROR) ? sst_pkg::E_BAD_BYTE : sst_pkg::E_NONE,
                          pos_q, 24'd1, line_q);
            cnt      = cnt + 2'd1;
          end
        end
      end
      pos_d = nxt;
    end
  end

  assign bundle_o.cnt = cnt;
  assign bundle_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sst_pkg::M_IDLE;
      quote_q <= 1'b0;
      wlen_q  <= '0;
      begin_q <= '0;
      pos_q   <= '0;
      line_q  <= 24'd1;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      wlen_q  <= wlen_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !is_end_i && wc_we) wc_q[wc_idx] <= ch_i;
  end

endmodule

>>> rtl/core/sst_outq.sv
module sst_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sst_pkg::bundle_t   bundle_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sst_pkg::tok_t      tok_o,
  output logic               last_o
);

  logic [1:0]          cnt_q, rd_q;
  sst_pkg::tok_t [2:0] res_q;
  logic                pop;
  logic [1:0]          left;

  assign out_valid_o = rd_q < cnt_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign left        = cnt_q - rd_q;
  // free when empty, or when the last buffered token leaves this cycle
  assign busy_o      = !(left == 2'd0 || (left == 2'd1 && pop));
  assign tok_o       = res_q[rd_q];
  assign last_o      = (rd_q == cnt_q - 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
      rd_q  <= '0;
    end else if (pop) begin
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= bundle_i.res;
  end

endmodule

>>> rtl/core/script_source_tokenizer.sv
// Streaming source tokenizer.
// Input channel: one source byte (ch_i) per transfer, or an end marker
// (is_end_i) that flushes the pending token, emits eof and restarts.
// Output channel: tokens with kind, error code, start offset, length and line;
// last_of_run_o marks the final token caused by one input transfer.
// Each input transfer yields zero to three tokens. The scanner state and the
// token bundle are computed combinationally and land in a result buffer; the
// first token is offered the cycle after the input transfer.
// Throughput: one byte per cycle while each byte gives at most one token and
// the output is not stalled; otherwise the input is held until the last token
// leaves the buffer by the single output port, one token per cycle unless stalled.
// in_stall_o rises while more than one buffered token is still waiting (or
// one that is stalled). A stalled output holds its token unchanged.
// Reset: idle scanner, offset 0, line 1, buffer empty.
module script_source_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        is_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [2:0]  error_kind_o,
  output logic [23:0] start_offset_o,
  output logic [23:0] token_length_o,
  output logic [23:0] line_number_o,
  output logic        last_of_run_o
);

  sst_pkg::bundle_t bundle;
  sst_pkg::tok_t    tok;
  logic             busy, accept;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  sst_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (ch_i),
    .is_end_i (is_end_i),
    .bundle_o (bundle)
  );

  sst_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .bundle_i    (bundle),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tok_o       (tok),
    .last_o      (last_of_run_o)
  );

  assign token_kind_o   = tok.kind;
  assign error_kind_o   = tok.err;
  assign start_offset_o = tok.start;
  assign token_length_o = tok.len;
  assign line_number_o  = tok.line;

endmodule

>>> rtl/core/sst_checker.sv
module sst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [5:0]  token_kind_o,
  input logic [2:0]  error_kind_o,
  input logic [23:0] token_length_o,
  input logic [23:0] line_number_o,
  input logic        last_of_run_o
);

  a_err_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((error_kind_o != sst_pkg::E_NONE) == (token_kind_o == sst_pkg::K_ERROR)))
    else $error("error code without error token");

  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o == sst_pkg::K_EOF) |->
      (last_of_run_o && token_length_o == 24'd0))
    else $error("eof token malformed");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_number_o != 24'd0))
    else $error("line number zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(token_kind_o)))
    else $error("stalled token changed");

endmodule

bind script_source_tokenizer sst_checker u_sst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .token_kind_o   (token_kind_o),
  .error_kind_o   (error_kind_o),
  .token_length_o (token_length_o),
  .line_number_o  (line_number_o),
  .last_of_run_o  (last_of_run_o)
);

>>> sim/tb_script_source_tokenizer.sv
`timescale 1ns / 1ps

module tb_script_source_tokenizer;

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [23:0] start;
    logic [23:0] len;
    logic [23:0] line;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i = '0;
  logic        is_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  token_kind_o;
  logic [2:0]  error_kind_o;
  logic [23:0] start_offset_o;
  logic [23:0] token_length_o;
  logic [23:0] line_number_o;
  logic        last_of_run_o;

  script_source_tokenizer i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // predictor state
  sst_pkg::mode_e scan_mode;
  logic           single_quote;
  logic [7:0]     word_buf [sst_pkg::KW_MAX_LEN];
  int unsigned    word_len;
  logic [23:0]    tok_begin, byte_pos, line_cnt;

  token_t      tokens_due[$];
  token_t      step_toks[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [23:0] span(logic [23:0] e);
    return (e >= tok_begin) ? e - tok_begin : 24'd0;
  endfunction

  function automatic void push_tok(logic [5:0] k, logic [2:0] e, logic [23:0] s,
                                   logic [23:0] l);
    token_t t;
    t.kind = k; t.err = e; t.start = s; t.len = l; t.line = line_cnt; t.last = 1'b0;
    if (step_toks.size() < 3) step_toks.push_back(t);
  endfunction

  function automatic void bump_line();
    if (line_cnt != sst_pkg::CNT_MAX) line_cnt++;
  endfunction

  function automatic logic [5:0] word_kind();
    string kws [15] = '{"fn", "if", "else", "while", "for", "return", "class", "use",
                        "const", "break", "continue", "match", "try", "catch", "yield"};
    logic hit;
    if (word_len > sst_pkg::KW_MAX_LEN) return sst_pkg::K_IDENT;
    for (int i = 0; i < 15; i++) begin
      if (kws[i].len() != word_len) continue;
      hit = 1'b1;
      for (int j = 0; j < word_len; j++)
        if (word_buf[j] != kws[i][j]) hit = 1'b0;
      if (hit) return sst_pkg::K_KW_FIRST + 6'(i);
    end
    return sst_pkg::K_IDENT;
  endfunction

  // one-byte operator or error for a pending operator mode
  function automatic void op_single(sst_pkg::mode_e m);
    case (m)
      sst_pkg::M_OP_MINUS: push_tok(sst_pkg::K_MINUS, sst_pkg::E_NONE, tok_begin, 24'd1);
      sst_pkg::M_OP_STAR:  push_tok(sst_pkg::K_STAR, sst_pkg::E_NONE, tok_begin, 24'd1);
      sst_pkg::M_OP_EQ:    push_tok(sst_pkg::K_ASSIGN, sst_pkg::E_NONE, tok_begin, 24'd1);
      sst_pkg::M_OP_BANG:  push_tok(sst_pkg::K_BANG, sst_pkg::E_NONE, tok_begin, 24'd1);
      sst_pkg::M_OP_LT:    push_tok(sst_pkg::K_LT, sst_pkg::E_NONE, tok_begin, 24'd1);
      sst_pkg::M_OP_GT:    push_tok(sst_pkg::K_GT, sst_pkg::E_NONE, tok_begin, 24'd1);
      sst_pkg::M_OP_AMP:   push_tok(sst_pkg::K_ERROR, sst_pkg::E_LONE_AMP, tok_begin, 24'd1);
      sst_pkg::M_OP_BAR:   push_tok(sst_pkg::K_ERROR, sst_pkg::E_LONE_BAR, tok_begin, 24'd1);
      default: ;
    endcase
  endfunction

  function automatic void flush_pending();
    logic [23:0] dp;
    case (scan_mode)
      sst_pkg::M_IDENT: push_tok(word_kind(), sst_pkg::E_NONE, tok_begin, span(byte_pos));
      sst_pkg::M_NUM:   push_tok(sst_pkg::K_INT, sst_pkg::E_NONE, tok_begin, span(byte_pos));
      sst_pkg::M_FRAC:  push_tok(sst_pkg::K_FLOAT, sst_pkg::E_NONE, tok_begin, span(byte_pos));
      sst_pkg::M_NUM_DOT: begin
        dp = (byte_pos > tok_begin) ? byte_pos - 24'd1 : byte_pos;
        push_tok(sst_pkg::K_INT, sst_pkg::E_NONE, tok_begin, span(dp));
        push_tok(sst_pkg::K_DOT, sst_pkg::E_NONE, dp, 24'd1);
      end
      sst_pkg::M_STR, sst_pkg::M_STR_ESC:
        push_tok(sst_pkg::K_ERROR, sst_pkg::E_UNTERM, tok_begin, span(byte_pos));
      sst_pkg::M_SLASH: push_tok(sst_pkg::K_SLASH, sst_pkg::E_NONE, tok_begin, 24'd1);
      default: op_single(scan_mode);
    endcase
    scan_mode = sst_pkg::M_IDLE;
  endfunction

  function automatic void open_tok(sst_pkg::mode_e m);
    scan_mode = m;
    tok_begin = byte_pos;
  endfunction

  function automatic void first_byte(logic [7:0] c);
    logic [5:0] k;
    k = sst_pkg::K_ERROR;
    if (c == " " || c == 8'd13 || c == 8'd9) return;
    if (c == 8'd10) begin
      bump_line();
      return;
    end
    if (is_alpha(c)) begin
      open_tok(sst_pkg::M_IDENT);
      word_buf[0] = c;
      word_len = 1;
      return;
    end
    if (is_digit(c)) begin
      open_tok(sst_pkg::M_NUM);
      return;
    end
    if (c == "\"" || c == "'") begin
      open_tok(sst_pkg::M_STR);
      single_quote = (c == "'");
      return;
    end
    case (c)
      "/": begin open_tok(sst_pkg::M_SLASH); return; end
      "-": begin open_tok(sst_pkg::M_OP_MINUS); return; end
      "*": begin open_tok(sst_pkg::M_OP_STAR); return; end
      "=": begin open_tok(sst_pkg::M_OP_EQ); return; end
      "!": begin open_tok(sst_pkg::M_OP_BANG); return; end
      "<": begin open_tok(sst_pkg::M_OP_LT); return; end
      ">": begin open_tok(sst_pkg::M_OP_GT); return; end
      "&": begin open_tok(sst_pkg::M_OP_AMP); return; end
      "|": begin open_tok(sst_pkg::M_OP_BAR); return; end
      "+": k = sst_pkg::K_PLUS;
      "%": k = sst_pkg::K_PERCENT;
      ":": k = sst_pkg::K_COLON;
      ";": k = sst_pkg::K_SEMI;
      ",": k = sst_pkg::K_COMMA;
      ".": k = sst_pkg::K_DOT;
      "(": k = sst_pkg::K_LPAREN;
      ")": k = sst_pkg::K_RPAREN;
      "{": k = sst_pkg::K_LBRACE;
      "}": k = sst_pkg::K_RBRACE;
      "[": k = sst_pkg::K_LBRACK;
      "]": k = sst_pkg::K_RBRACK;
      default: ;
    endcase
    if (k == sst_pkg::K_ERROR) push_tok(sst_pkg::K_ERROR, sst_pkg::E_BAD_BYTE, byte_pos, 24'd1);
    else push_tok(k, sst_pkg::E_NONE, byte_pos, 24'd1);
  endfunction

  // returns 1 when the pending token absorbs the byte
  function automatic logic pending_byte(logic [7:0] c);
    logic [23:0] nxt;
    logic [7:0]  second;
    logic [5:0]  pair;
    nxt = (byte_pos != sst_pkg::POS_MAX) ? byte_pos + 24'd1 : byte_pos;
    case (scan_mode)
      sst_pkg::M_IDLE: return 1'b0;
      sst_pkg::M_IDENT: if (is_alpha(c) || is_digit(c)) begin
        if (word_len < sst_pkg::KW_MAX_LEN) word_buf[word_len] = c;
        if (word_len <= sst_pkg::KW_MAX_LEN) word_len++;
        return 1'b1;
      end
      sst_pkg::M_NUM: begin
        if (is_digit(c)) return 1'b1;
        if (c == ".") begin
          scan_mode = sst_pkg::M_NUM_DOT;
          return 1'b1;
        end
      end
      sst_pkg::M_NUM_DOT: if (is_digit(c)) begin
        scan_mode = sst_pkg::M_FRAC;
        return 1'b1;
      end
      sst_pkg::M_FRAC: if (is_digit(c)) return 1'b1;
      sst_pkg::M_STR: begin
        if (c == (single_quote ? 8'h27 : 8'h22)) begin
          push_tok(sst_pkg::K_STRING, sst_pkg::E_NONE, tok_begin, span(nxt));
          scan_mode = sst_pkg::M_IDLE;
        end else if (c == "\\") scan_mode = sst_pkg::M_STR_ESC;
        else if (c == 8'd10) bump_line();
        return 1'b1;
      end
      sst_pkg::M_STR_ESC: begin
        scan_mode = sst_pkg::M_STR;
        return 1'b1;
      end
      sst_pkg::M_SLASH: begin
        if (c == "/") begin
          scan_mode = sst_pkg::M_LINE_CMT;
          return 1'b1;
        end
        if (c == "*") begin
          scan_mode = sst_pkg::M_BLOCK_CMT;
          return 1'b1;
        end
      end
      sst_pkg::M_LINE_CMT: begin
        if (c == 8'd10) begin
          bump_line();
          scan_mode = sst_pkg::M_IDLE;
        end
        return 1'b1;
      end
      sst_pkg::M_BLOCK_CMT: begin
        if (c == 8'd10) bump_line();
        else if (c == "*") scan_mode = sst_pkg::M_BLOCK_STAR;
        return 1'b1;
      end
      sst_pkg::M_BLOCK_STAR: begin
        if (c == "/") scan_mode = sst_pkg::M_IDLE;
        else if (c != "*") begin
          if (c == 8'd10) bump_line();
          scan_mode = sst_pkg::M_BLOCK_CMT;
        end
        return 1'b1;
      end
      default: begin
        case (scan_mode)
          sst_pkg::M_OP_MINUS: begin second = ">"; pair = sst_pkg::K_ARROW; end
          sst_pkg::M_OP_STAR:  begin second = "*"; pair = sst_pkg::K_POW; end
          sst_pkg::M_OP_EQ:    begin second = "="; pair = sst_pkg::K_EQEQ; end
          sst_pkg::M_OP_BANG:  begin second = "="; pair = sst_pkg::K_NE; end
          sst_pkg::M_OP_LT:    begin second = "="; pair = sst_pkg::K_LE; end
          sst_pkg::M_OP_GT:    begin second = "="; pair = sst_pkg::K_GE; end
          sst_pkg::M_OP_AMP:   begin second = "&"; pair = sst_pkg::K_ANDAND; end
          default:             begin second = "|"; pair = sst_pkg::K_OROR; end
        endcase
        if (c == second) begin
          push_tok(pair, sst_pkg::E_NONE, tok_begin, span(nxt));
          scan_mode = sst_pkg::M_IDLE;
          return 1'b1;
        end
      end
    endcase
    flush_pending();
    return 1'b0;
  endfunction

  function automatic void scanner_reset();
    scan_mode = sst_pkg::M_IDLE;
    single_quote = 1'b0;
    foreach (word_buf[i]) word_buf[i] = '0;
    word_len = 0;
    tok_begin = '0;
    byte_pos = '0;
    line_cnt = 24'd1;
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic fin);
    step_toks.delete();
    if (fin) begin
      flush_pending();
      push_tok(sst_pkg::K_EOF, sst_pkg::E_NONE, byte_pos, 24'd0);
      scanner_reset();
    end else begin
      if (!pending_byte(c)) first_byte(c);
      if (byte_pos != sst_pkg::POS_MAX) byte_pos++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    token_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("unexpected token kind", token_kind_o, 0);
      end else begin
        w = tokens_due.pop_front();
        if (token_kind_o != w.kind) report_mismatch("kind", token_kind_o, w.kind);
        if (error_kind_o != w.err) report_mismatch("error", error_kind_o, w.err);
        if (start_offset_o != w.start) report_mismatch("start", start_offset_o, w.start);
        if (token_length_o != w.len) report_mismatch("length", token_length_o, w.len);
        if (line_number_o != w.line) report_mismatch("line", line_number_o, w.line);
        if (last_of_run_o != w.last) report_mismatch("last", last_of_run_o, w.last);
      end
    end
  end

  // receiver stall; a long hold-off overrides the random stall
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] c, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    is_end_i <= fin;
    // stall as seen at the edge itself decides the transfer
    @(posedge clk_i iff !in_stall_o);
    predict_tokens(c, fin);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tokens_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_operators_keywords();
    send_text("fn if else while for return class use const break continue match ");
    send_text("try catch yield x_9 continues + -> - ** * / % == = != ! <= < >= > && || ");
    send_text(":;,.(){}[]&x|y");
    send_byte(8'd0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'd7, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'd0, 1'b1);
  endtask

  task automatic test_numbers_strings();
    send_text("12 3.45 1.x 7.\n\"a\\\"b\" 'c\\\n' \"open\n");
    send_byte(8'd0, 1'b1);
    send_text("\"tail\\");
    send_byte(8'd0, 1'b1);
    send_text("9.");
    send_byte(8'd0, 1'b1);
    send_text("a // c\n/* x\n**/ b /* open");
    send_byte(8'd0, 1'b1);
    send_text("=");
    send_byte(8'd0, 1'b1);
  endtask

  function automatic logic [7:0] pick_char();
    string pool = "aZ_09.\"'\\/*-=!<>&|+%:;,(){}[] \n\t\rfnx";
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      default: return pool[$urandom_range(pool.len() - 1)];
    endcase
  endfunction

  // fragments of well-formed source, with random noise bytes and end markers mixed in
  task automatic random_source(int n);
    string frags [12] = '{"while ", "x1 = 42;", "y=3.14 ", "\"s\\n\" ", "'q' ",
                          "// c\n", "/* b\n*/", "a->b ", "p**2 ", "c&&d||e ",
                          "if(a<=b){", "}\n"};
    string f;
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(3) == 0) begin
        send_byte(pick_char(), 1'b0);
        sent++;
      end else begin
        f = frags[$urandom_range(11)];
        send_text(f);
        sent += f.len();
      end
      if ($urandom_range(40) == 0) begin
        send_byte(8'($urandom_range(255)), 1'b1);
        sent++;
      end
    end
    send_byte(8'd0, 1'b1);
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_source(10);
    send_idle_pct = 75; recv_stall_pct = 0;  random_source(10);
    send_idle_pct = 0;  recv_stall_pct = 75; random_source(10);
    send_idle_pct = 38; recv_stall_pct = 38; random_source(10);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 60;
    send_text("+-*%;,()");
    drain();
    send_text("a.1 b");
    send_byte(8'd0, 1'b1);
  endtask

  initial begin
    scanner_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_operators_keywords();
    test_numbers_strings();
    test_backpressure();
    test_random_phases();
    drain();
    recv_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && tokens_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
